/* sv/rfc_pkg.sv */
// rfc_pkg: shared types, constants and helper functions for the RGB fade controller.
// Used by rfc_interp and rgb_fade_controller_unit; has no dependencies of its own.
package rfc_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int STEP_W            = 16;
    localparam int LVL_W             = 8;
    localparam int CMD_W             = 4;
    localparam int QUO_W             = 8;
    localparam int NUM_CH            = 3;
    localparam int PROD_W            = LVL_W + STEP_W;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd10;
    localparam logic [LVL_W-1:0]  FULL_SCALE = 8'd99;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 4'd0,
        CMD_HARD_ON    = 4'd1,
        CMD_HARD_OFF   = 4'd2,
        CMD_FADE_ON    = 4'd3,
        CMD_FADE_OFF   = 4'd4,
        CMD_SET_LEVEL  = 4'd5,
        CMD_FADE_LEVEL = 4'd6,
        CMD_SET_COLOR  = 4'd7,
        CMD_FADE_COLOR = 4'd8,
        CMD_TOGGLE     = 4'd9
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK_CHK,
        ST_TICK_SPAN,
        ST_TICK_END,
        ST_INTERP,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ip_stat_t;

    // x * 99 / 255, truncated; divide by 255 via (p + (p >> 8) + 1) >> 8
    function automatic logic [LVL_W-1:0] scale_level(input logic [LVL_W-1:0] x);
        logic [14:0] p;
        logic [15:0] s;
        p = 15'(x) * 15'(FULL_SCALE);
        s = 16'(p) + 16'(p >> 8) + 16'd1;
        return s[15:8];
    endfunction

    function automatic logic [LVL_W-1:0] abs_diff(input logic [LVL_W-1:0] a,
                                                   input logic [LVL_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* sv/rfc_interp.sv */
// rfc_interp: shared interpolation unit, elapsed * delta / span for one channel.
// One multiply on start, then an 8-step restoring divide. Depends on rfc_pkg.
module rfc_interp #(
    parameter int TIME_BITS = rfc_pkg::TIME_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [TIME_BITS-1:0]      elapsed,
    input  logic [TIME_BITS-1:0]      span,
    input  logic [rfc_pkg::LVL_W-1:0] delta,
    output rfc_pkg::ip_stat_t         stat,
    output logic [rfc_pkg::QUO_W-1:0] quotient
);
    import rfc_pkg::*;

    localparam int DW = TIME_BITS + LVL_W;
    localparam int CW = $clog2(QUO_W);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    dsh_reg, dsh_next;
    logic [QUO_W-1:0] q_reg, q_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ge;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ge        = (rem_reg >= dsh_reg);
        if (start)
        begin
            rem_next  = DW'(elapsed) * DW'(delta);
            dsh_next  = DW'(span) << (QUO_W - 1);
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[QUO_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign stat     = '{busy: busy_reg, done: done_reg};
    assign quotient = q_reg;

endmodule

/* sv/rgb_fade_controller_unit.sv */
// rgb_fade_controller_unit: three-channel RGB controller with linear fades.
// Command sequencer and light state; uses rfc_pkg and one shared rfc_interp unit.
//
//   channel   signals                                  direction
//   command   cmd_valid, cmd_stall, command, red,      in
//             green, blue
//   result    res_valid, res_stall, out_red,           out
//             out_green, out_blue, is_on, fading
//   config    step_wr_en, step_wr_data                 in
//
// Non-tick commands pass through EXEC and FINISH; a tick with no step due adds TICK_CHK.
// A fade step adds TICK_SPAN, TICK_END and, unless the fade ends, a divide per channel.
// cmd_stall is high from acceptance until the result is loaded into the output register.
// Reset: levels 99, light off, no fade, step time 10 ms.
// A held result (res_stall high) delays loading of the next one only.
module rgb_fade_controller_unit #(
    parameter int TIME_BITS = rfc_pkg::TIME_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step_wr_en,
    input  logic [rfc_pkg::STEP_W-1:0] step_wr_data,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  logic [rfc_pkg::CMD_W-1:0]  command,
    input  logic [rfc_pkg::LVL_W-1:0]  red,
    input  logic [rfc_pkg::LVL_W-1:0]  green,
    input  logic [rfc_pkg::LVL_W-1:0]  blue,
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic [rfc_pkg::LVL_W-1:0]  out_red,
    output logic [rfc_pkg::LVL_W-1:0]  out_green,
    output logic [rfc_pkg::LVL_W-1:0]  out_blue,
    output logic                       is_on,
    output logic                       fading
);
    import rfc_pkg::*;

    localparam int PW = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;

    state_t               state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [LVL_W-1:0]     raw_reg [NUM_CH];
    logic [LVL_W-1:0]     raw_next [NUM_CH];
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [TIME_BITS-1:0] begin_reg, begin_next;
    logic [TIME_BITS-1:0] fin_reg, fin_next;
    logic [TIME_BITS-1:0] span_reg, span_next;
    logic [TIME_BITS-1:0] el_reg, el_next;
    logic [LVL_W-1:0]     cur_reg [NUM_CH];
    logic [LVL_W-1:0]     cur_next [NUM_CH];
    logic [LVL_W-1:0]     start_reg [NUM_CH];
    logic [LVL_W-1:0]     start_next [NUM_CH];
    logic [LVL_W-1:0]     tgt_reg [NUM_CH];
    logic [LVL_W-1:0]     tgt_next [NUM_CH];
    logic [LVL_W-1:0]     bak_reg [NUM_CH];
    logic [LVL_W-1:0]     bak_next [NUM_CH];
    logic                 on_reg, on_next;
    logic [1:0]           chan_reg, chan_next;
    logic                 res_valid_reg, res_valid_next;
    logic [LVL_W-1:0]     ored_reg, ogrn_reg, oblu_reg;
    logic                 oon_reg, ofade_reg;
    logic                 out_load;

    logic [LVL_W-1:0]     col [NUM_CH];
    logic [LVL_W-1:0]     goal [NUM_CH];
    logic [LVL_W-1:0]     big;
    logic [PROD_W-1:0]    prod;
    logic [TIME_BITS-1:0] fin_calc;
    logic [TIME_BITS-1:0] last_plus;
    logic [TIME_BITS-1:0] now_plus;
    logic                 do_fade;
    logic                 ip_start;
    logic [LVL_W-1:0]     ip_delta;
    logic [QUO_W-1:0]     ip_quo;
    ip_stat_t             ip_stat;
    logic                 ip_neg;
    logic [LVL_W-1:0]     new_lvl;

    rfc_interp #(
        .TIME_BITS (TIME_BITS)
    ) u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ip_start),
        .elapsed  (el_reg),
        .span     (span_reg),
        .delta    (ip_delta),
        .stat     (ip_stat),
        .quotient (ip_quo)
    );

    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            col[k] = scale_level(raw_reg[k]);
            case (cmd_reg)
                CMD_FADE_ON:    goal[k] = bak_reg[k];
                CMD_FADE_LEVEL: goal[k] = raw_reg[0];
                CMD_FADE_COLOR: goal[k] = col[k];
                default:        goal[k] = '0;
            endcase
        end
        big = '0;
        for (int k = 0; k < NUM_CH; k++)
        begin
            if (abs_diff(cur_reg[k], goal[k]) > big)
            begin
                big = abs_diff(cur_reg[k], goal[k]);
            end
        end
    end

    assign prod      = PROD_W'(big) * PROD_W'(step_reg);
    assign fin_calc  = TIME_BITS'(PW'(now_reg) + PW'(prod));
    assign last_plus = last_reg + TIME_BITS'(step_reg);
    assign now_plus  = now_reg + TIME_BITS'(step_reg);
    assign ip_start  = (state_reg == ST_INTERP);
    assign ip_delta  = abs_diff(tgt_reg[chan_reg], start_reg[chan_reg]);
    assign ip_neg    = tgt_reg[chan_reg] < start_reg[chan_reg];
    assign new_lvl   = ip_neg ? (start_reg[chan_reg] - ip_quo)
                              : (start_reg[chan_reg] + ip_quo);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        raw_next       = raw_reg;
        step_next      = step_reg;
        now_next       = now_reg;
        last_next      = last_reg;
        begin_next     = begin_reg;
        fin_next       = fin_reg;
        span_next      = span_reg;
        el_next        = el_reg;
        cur_next       = cur_reg;
        start_next     = start_reg;
        tgt_next       = tgt_reg;
        bak_next       = bak_reg;
        on_next        = on_reg;
        chan_next      = chan_reg;
        res_valid_next = res_valid_reg;
        out_load       = 1'b0;
        do_fade        = 1'b0;

        if (step_wr_en)
        begin
            step_next = step_wr_data;
        end
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = command;
                    raw_next[0] = red;
                    raw_next[1] = green;
                    raw_next[2] = blue;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        now_next   = now_reg + 1'b1;
                        state_next = ST_TICK_CHK;
                    end
                    CMD_HARD_ON:
                    begin
                        if (!on_reg)
                        begin
                            on_next  = 1'b1;
                            cur_next = bak_reg;
                        end
                    end
                    CMD_HARD_OFF:
                    begin
                        if (on_reg)
                        begin
                            on_next  = 1'b0;
                            bak_next = tgt_reg;
                            for (int k = 0; k < NUM_CH; k++)
                            begin
                                cur_next[k] = '0;
                            end
                        end
                    end
                    CMD_FADE_ON:
                    begin
                        if (!on_reg)
                        begin
                            on_next = 1'b1;
                            do_fade = 1'b1;
                        end
                    end
                    CMD_FADE_OFF:
                    begin
                        if (on_reg)
                        begin
                            on_next  = 1'b0;
                            bak_next = tgt_reg;
                            do_fade  = 1'b1;
                        end
                    end
                    CMD_SET_LEVEL:
                    begin
                        for (int k = 0; k < NUM_CH; k++)
                        begin
                            cur_next[k] = raw_reg[0];
                            tgt_next[k] = raw_reg[0];
                        end
                        on_next = (raw_reg[0] != '0);
                    end
                    CMD_FADE_LEVEL:
                    begin
                        on_next = (raw_reg[0] != '0);
                        do_fade = 1'b1;
                    end
                    CMD_SET_COLOR:
                    begin
                        cur_next = col;
                        tgt_next = col;
                        on_next  = (col[0] != '0) || (col[1] != '0) || (col[2] != '0);
                    end
                    CMD_FADE_COLOR:
                    begin
                        on_next = (raw_reg[0] != '0) || (raw_reg[1] != '0)
                               || (raw_reg[2] != '0);
                        do_fade = 1'b1;
                    end
                    CMD_TOGGLE:
                    begin
                        if (!on_reg)
                        begin
                            cur_next = bak_reg;
                        end
                        else
                        begin
                            bak_next = tgt_reg;
                            for (int k = 0; k < NUM_CH; k++)
                            begin
                                cur_next[k] = '0;
                            end
                        end
                        on_next = !on_reg;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
                if (do_fade)
                begin
                    tgt_next   = goal;
                    start_next = cur_reg;
                    begin_next = now_reg;
                    fin_next   = fin_calc;
                end
            end
            ST_TICK_CHK:
            begin
                if ((fin_reg == '0) || (now_reg < last_plus))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    last_next  = now_reg;
                    state_next = ST_TICK_SPAN;
                end
            end
            ST_TICK_SPAN:
            begin
                span_next  = fin_reg - begin_reg;
                el_next    = now_reg - begin_reg;
                state_next = ST_TICK_END;
            end
            ST_TICK_END:
            begin
                // last step time equals now here
                if ((now_plus > fin_reg) || (span_reg == '0))
                begin
                    cur_next   = tgt_reg;
                    fin_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (el_reg > span_reg)
                    begin
                        el_next = span_reg;
                    end
                    chan_next  = '0;
                    state_next = ST_INTERP;
                end
            end
            ST_INTERP:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (ip_stat.done)
                begin
                    cur_next[chan_reg] = new_lvl;
                    if (chan_reg == 2'(NUM_CH - 1))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        chan_next  = chan_reg + 1'b1;
                        state_next = ST_INTERP;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    out_load       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RESET;
            now_reg       <= '0;
            last_reg      <= '0;
            begin_reg     <= '0;
            fin_reg       <= '0;
            on_reg        <= 1'b0;
            chan_reg      <= '0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_CH; k++)
            begin
                cur_reg[k]   <= FULL_SCALE;
                start_reg[k] <= FULL_SCALE;
                tgt_reg[k]   <= FULL_SCALE;
                bak_reg[k]   <= FULL_SCALE;
            end
        end
        else
        begin
            step_reg      <= step_next;
            now_reg       <= now_next;
            last_reg      <= last_next;
            begin_reg     <= begin_next;
            fin_reg       <= fin_next;
            on_reg        <= on_next;
            chan_reg      <= chan_next;
            res_valid_reg <= res_valid_next;
            cur_reg       <= cur_next;
            start_reg     <= start_next;
            tgt_reg       <= tgt_next;
            bak_reg       <= bak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        raw_reg  <= raw_next;
        span_reg <= span_next;
        el_reg   <= el_next;
        if (out_load)
        begin
            ored_reg  <= cur_reg[0];
            ogrn_reg  <= cur_reg[1];
            oblu_reg  <= cur_reg[2];
            oon_reg   <= on_reg;
            ofade_reg <= (fin_reg != '0);
        end
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign out_red   = ored_reg;
    assign out_green = ogrn_reg;
    assign out_blue  = oblu_reg;
    assign is_on     = oon_reg;
    assign fading    = ofade_reg;

`ifndef SYNTHESIS
    a_res_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish state");

    a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ip_stat.busy)
        else $error("interpolation unit busy while sequencer idle");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ip_stat.done |-> (state_reg == ST_WAIT))
        else $error("interpolation done outside wait state");

    a_end_at_target: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && $past(state_reg == ST_TICK_END))
        |-> ((fin_reg == '0) && (cur_reg[0] == tgt_reg[0])
             && (cur_reg[1] == tgt_reg[1]) && (cur_reg[2] == tgt_reg[2])))
        else $error("fade ended away from target");
`endif

endmodule
